>>> hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// Sphere pair relation classifier: shared definitions
// Default geometry width, register map and side-band types.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int COORD_BITS_DEF = 24;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index (paddr[2])
    localparam logic [0:0] REG_EQUAL_TOL = 1'b0;

    localparam int TOL_W = 8;
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

    // approximate-equality results that ride along with the root pipeline
    typedef struct packed {
        logic congruent;
        logic concentric;
    } t_near;

endpackage

>>> hw/rtl/spc_prep.sv
// ----------------------------------------------------------------------------
// Sphere pair relation classifier: front end
// Three stages: absolute coordinate deltas and tolerance checks, squares,
// sum of squares.
// ----------------------------------------------------------------------------
module spc_prep
    import spc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [TOL_W-1:0]             i_tol,
    input  logic signed [COORD_BITS-1:0] i_a_center_x,
    input  logic signed [COORD_BITS-1:0] i_a_center_y,
    input  logic signed [COORD_BITS-1:0] i_a_center_z,
    input  logic [COORD_BITS-2:0]        i_a_radius,
    input  logic signed [COORD_BITS-1:0] i_b_center_x,
    input  logic signed [COORD_BITS-1:0] i_b_center_y,
    input  logic signed [COORD_BITS-1:0] i_b_center_z,
    input  logic [COORD_BITS-2:0]        i_b_radius,
    output logic                         o_valid,
    output logic [2*COORD_BITS+1:0]      o_sq,
    output logic [COORD_BITS-2:0]        o_a_radius,
    output logic [COORD_BITS-2:0]        o_b_radius,
    output t_near                        o_near
);

    localparam int RW  = COORD_BITS - 1;
    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * DW;

    logic [COORD_BITS-1:0] w_a [3];
    logic [COORD_BITS-1:0] w_b [3];
    logic [DW-1:0]         w_abs [3];
    logic [2:0]            w_near_c;
    logic [RW:0]           w_rdiff;
    logic [RW-1:0]         w_rabs;
    logic                  w_congruent;

    // stage 1
    logic          r_v1;
    logic [DW-1:0] r_abs [3];
    logic [RW-1:0] r_ra1, r_rb1;
    t_near         r_near1;
    // stage 2
    logic           r_v2;
    logic [SQW-1:0] r_sq2 [3];
    logic [RW-1:0]  r_ra2, r_rb2;
    t_near          r_near2;
    // stage 3
    logic           r_v3;
    logic [SQW-1:0] r_sum;
    logic [RW-1:0]  r_ra3, r_rb3;
    t_near          r_near3;

    assign w_a[0] = i_a_center_x;
    assign w_a[1] = i_a_center_y;
    assign w_a[2] = i_a_center_z;
    assign w_b[0] = i_b_center_x;
    assign w_b[1] = i_b_center_y;
    assign w_b[2] = i_b_center_z;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic [DW-1:0] w_diff;
        assign w_diff = {w_a[g][COORD_BITS-1], w_a[g]} - {w_b[g][COORD_BITS-1], w_b[g]};
        // -(-2^N) wraps to 2^N, which is the right magnitude read unsigned
        assign w_abs[g]    = w_diff[DW-1] ? (~w_diff + DW'(1)) : w_diff;
        assign w_near_c[g] = w_abs[g] <= DW'(i_tol);
    end

    assign w_rdiff     = {1'b0, i_a_radius} - {1'b0, i_b_radius};
    assign w_rabs      = w_rdiff[RW] ? RW'(~w_rdiff + (RW+1)'(1)) : w_rdiff[RW-1:0];
    assign w_congruent = DW'(w_rabs) <= DW'(i_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_abs[i] <= w_abs[i];
                r_sq2[i] <= SQW'(r_abs[i]) * SQW'(r_abs[i]);
            end
            r_ra1              <= i_a_radius;
            r_rb1              <= i_b_radius;
            r_near1.congruent  <= w_congruent;
            r_near1.concentric <= &w_near_c;

            r_ra2   <= r_ra1;
            r_rb2   <= r_rb1;
            r_near2 <= r_near1;

            // three squares of at most 2^(2N) each cannot carry out of SQW bits
            r_sum   <= r_sq2[0] + r_sq2[1] + r_sq2[2];
            r_ra3   <= r_ra2;
            r_rb3   <= r_rb2;
            r_near3 <= r_near2;
        end
    end

    assign o_valid    = r_v3;
    assign o_sq       = r_sum;
    assign o_a_radius = r_ra3;
    assign o_b_radius = r_rb3;
    assign o_near     = r_near3;

endmodule

>>> hw/rtl/spc_root.sv
// ----------------------------------------------------------------------------
// Sphere pair relation classifier: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, MSB first.
// Side-band bits travel alongside unchanged.
// ----------------------------------------------------------------------------
module spc_root
    import spc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2*COORD_BITS+1:0] i_sq,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [COORD_BITS:0]     o_root,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int RTW = COORD_BITS + 1;
    localparam int SQW = 2 * RTW;

    logic [SQW-1:0]    r_rem  [RTW];
    logic [RTW-1:0]    r_root [RTW];
    logic [SIDE_W-1:0] r_side [RTW];
    logic              r_vld  [RTW];

    for (genvar s = 0; s < RTW; s++) begin : g_stage
        localparam int K = COORD_BITS - s;

        logic [SQW-1:0]    w_rem_in;
        logic [RTW-1:0]    w_root_in;
        logic [SIDE_W-1:0] w_side_in;
        logic              w_vld_in;
        logic [SQW-1:0]    w_trial;
        logic              w_take;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_sq;
            assign w_root_in = '0;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_side_in = r_side[s-1];
            assign w_vld_in  = r_vld[s-1];
        end

        // (r + 2^k)^2 - r^2; r only has bits above k, so the OR is a sum
        assign w_trial = (SQW'(w_root_in) << (K + 1)) | (SQW'(1) << (2 * K));
        assign w_take  = w_rem_in >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_take ? (w_rem_in - w_trial) : w_rem_in;
                r_root[s] <= w_take ? (w_root_in | (RTW'(1) << K)) : w_root_in;
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[RTW-1];
    assign o_root  = r_root[RTW-1];
    assign o_side  = r_side[RTW-1];

endmodule

>>> hw/rtl/spc_relate.sv
// ----------------------------------------------------------------------------
// Sphere pair relation classifier: relation flags
// Stage 1 forms the radius/distance sums, stage 2 compares them and holds
// the result transaction.
// ----------------------------------------------------------------------------
module spc_relate
    import spc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [TOL_W-1:0]      i_tol,
    input  logic [COORD_BITS:0]   i_dist,
    input  logic [COORD_BITS-2:0] i_a_radius,
    input  logic [COORD_BITS-2:0] i_b_radius,
    input  t_near                 i_near,
    output logic                  o_valid,
    output logic [COORD_BITS:0]   o_center_distance,
    output logic                  o_identical,
    output logic                  o_congruent,
    output logic                  o_concentric,
    output logic                  o_a_holds_b,
    output logic                  o_b_holds_a,
    output logic                  o_touch_outside,
    output logic                  o_touch_inside,
    output logic                  o_overlap,
    output logic                  o_intersect_res
);

    localparam int EW = COORD_BITS + 2;

    // stage 1
    logic          r_v1;
    logic [EW-1:0] r_ra, r_rb, r_d;
    logic [EW-1:0] r_sum_ab, r_rb_d, r_ra_d;
    t_near         r_near;

    logic          w_a_holds, w_b_holds, w_either;
    logic          w_tin_a, w_tin_b, w_tout_near, w_ovl;
    logic [EW-1:0] w_tout_diff, w_ex_a, w_ex_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ra     <= EW'(i_a_radius);
            r_rb     <= EW'(i_b_radius);
            r_d      <= EW'(i_dist);
            r_sum_ab <= EW'(i_a_radius) + EW'(i_b_radius);
            r_rb_d   <= EW'(i_b_radius) + EW'(i_dist);
            r_ra_d   <= EW'(i_a_radius) + EW'(i_dist);
            r_near   <= i_near;
        end
    end

    assign w_a_holds   = r_ra >= r_rb_d;
    assign w_b_holds   = r_rb >= r_ra_d;
    assign w_either    = w_a_holds | w_b_holds;
    // excess only meaningful when the matching holds flag is set
    assign w_ex_a      = r_ra - r_rb_d;
    assign w_ex_b      = r_rb - r_ra_d;
    assign w_tin_a     = w_a_holds & (w_ex_a <= EW'(i_tol));
    assign w_tin_b     = w_b_holds & (w_ex_b <= EW'(i_tol));
    assign w_ovl       = r_d < r_sum_ab;
    assign w_tout_diff = w_ovl ? (r_sum_ab - r_d) : (r_d - r_sum_ab);
    assign w_tout_near = w_tout_diff <= EW'(i_tol);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_center_distance <= r_d[COORD_BITS:0];
            o_identical       <= r_near.congruent & r_near.concentric;
            o_congruent       <= r_near.congruent;
            o_concentric      <= r_near.concentric;
            o_a_holds_b       <= w_a_holds;
            o_b_holds_a       <= w_b_holds;
            o_touch_outside   <= ~w_either & w_tout_near;
            o_touch_inside    <= w_tin_a | w_tin_b;
            o_overlap         <= w_ovl;
            o_intersect_res   <= w_ovl & ~w_either;
        end
    end

endmodule

>>> hw/rtl/sphere_pair_relation_classifier_unit.sv
// ----------------------------------------------------------------------------
// Sphere pair relation classifier
// Takes one sphere pair per cycle, unless the output stalls, and returns the
// floored centre distance and nine relation flags. It has three front-end
// stages for deltas, squares and their sum, COORD_BITS + 1 square-root
// stages that each settle one bit of the distance, and two stages for the
// relation compares, the last of which is the output register. Throughput
// is one transaction per cycle; a stall on the output freezes every stage
// together, so nothing is dropped or duplicated. Equality tests use the
// equal_tolerance register at byte address 0 (reset value 1); change it
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module sphere_pair_relation_classifier_unit
    import spc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_AW-1:0]            paddr,
    input  logic [APB_DW-1:0]            pwdata,
    output logic [APB_DW-1:0]            prdata,
    output logic                         pready,
    // sphere pairs in
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_a_center_x,
    input  logic signed [COORD_BITS-1:0] i_a_center_y,
    input  logic signed [COORD_BITS-1:0] i_a_center_z,
    input  logic [COORD_BITS-2:0]        i_a_radius,
    input  logic signed [COORD_BITS-1:0] i_b_center_x,
    input  logic signed [COORD_BITS-1:0] i_b_center_y,
    input  logic signed [COORD_BITS-1:0] i_b_center_z,
    input  logic [COORD_BITS-2:0]        i_b_radius,
    // relations out
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [COORD_BITS:0]          o_center_distance,
    output logic                         o_identical,
    output logic                         o_congruent,
    output logic                         o_concentric,
    output logic                         o_a_holds_b,
    output logic                         o_b_holds_a,
    output logic                         o_touch_outside,
    output logic                         o_touch_inside,
    output logic                         o_overlap,
    output logic                         o_intersect_res
);

    localparam int RW     = COORD_BITS - 1;
    localparam int SQW    = 2 * COORD_BITS + 2;
    localparam int SIDE_W = 2 * RW + $bits(t_near);

    logic [TOL_W-1:0]  r_tol;
    logic              w_adv;

    logic              w_p_valid;
    logic [SQW-1:0]    w_p_sq;
    logic [RW-1:0]     w_p_ra, w_p_rb;
    t_near             w_p_near;

    logic              w_r_valid;
    logic [COORD_BITS:0] w_r_root;
    logic [SIDE_W-1:0] w_r_side;
    logic [RW-1:0]     w_r_ra, w_r_rb;
    t_near             w_r_near;

    // register access
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_EQUAL_TOL)) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_EQUAL_TOL) ? {{(APB_DW-TOL_W){1'b0}}, r_tol} : '0;

    // whole pipeline moves when the output register is free or being drained
    assign w_adv   = ~o_valid | i_ready;
    assign o_ready = w_adv;

    spc_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_valid      (i_valid),
        .i_tol        (r_tol),
        .i_a_center_x (i_a_center_x),
        .i_a_center_y (i_a_center_y),
        .i_a_center_z (i_a_center_z),
        .i_a_radius   (i_a_radius),
        .i_b_center_x (i_b_center_x),
        .i_b_center_y (i_b_center_y),
        .i_b_center_z (i_b_center_z),
        .i_b_radius   (i_b_radius),
        .o_valid      (w_p_valid),
        .o_sq         (w_p_sq),
        .o_a_radius   (w_p_ra),
        .o_b_radius   (w_p_rb),
        .o_near       (w_p_near)
    );

    spc_root #(
        .COORD_BITS (COORD_BITS),
        .SIDE_W     (SIDE_W)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_p_valid),
        .i_sq    (w_p_sq),
        .i_side  ({w_p_ra, w_p_rb, w_p_near}),
        .o_valid (w_r_valid),
        .o_root  (w_r_root),
        .o_side  (w_r_side)
    );

    assign {w_r_ra, w_r_rb, w_r_near} = w_r_side;

    spc_relate #(
        .COORD_BITS (COORD_BITS)
    ) u_relate (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_adv),
        .i_valid           (w_r_valid),
        .i_tol             (r_tol),
        .i_dist            (w_r_root),
        .i_a_radius        (w_r_ra),
        .i_b_radius        (w_r_rb),
        .i_near            (w_r_near),
        .o_valid           (o_valid),
        .o_center_distance (o_center_distance),
        .o_identical       (o_identical),
        .o_congruent       (o_congruent),
        .o_concentric      (o_concentric),
        .o_a_holds_b       (o_a_holds_b),
        .o_b_holds_a       (o_b_holds_a),
        .o_touch_outside   (o_touch_outside),
        .o_touch_inside    (o_touch_inside),
        .o_overlap         (o_overlap),
        .o_intersect_res   (o_intersect_res)
    );

endmodule

>>> verif/sphere_pair_relation_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere pair relation classifier testbench
// Drives sphere pairs through the valid/ready input with random gaps and
// stalls the result side at random. A scoreboard predicts the distance and
// relation flags of each accepted pair and checks results in order. The
// equality tolerance is set through the APB port between phases, with the
// pipeline drained first.
// ----------------------------------------------------------------------------
module sphere_pair_relation_classifier_unit_tb;
    import spc_pkg::*;

    localparam int CB   = COORD_BITS_DEF;
    localparam int CMAX = (1 << (CB - 1)) - 1;
    localparam int CMIN = -(1 << (CB - 1));
    localparam int RMAX = (1 << (CB - 1)) - 1;

    // index with no register behind it; writes there must be ignored
    localparam logic [0:0] REG_UNUSED = 1'b1;

    typedef struct {
        logic signed [CB-1:0] ax, ay, az;
        logic [CB-2:0]        ra;
        logic signed [CB-1:0] bx, by, bz;
        logic [CB-2:0]        rb;
    } sphere_pair_t;

    typedef struct {
        logic [CB:0] center_dist;
        logic        identical, congruent, concentric, a_holds_b, b_holds_a;
        logic        touch_outside, touch_inside, overlap, intersect_res;
    } relation_t;

    class relation_scoreboard;
        logic [TOL_W-1:0] tol_reg;
        relation_t        expected_q[$];
        int               errors;

        function new();
            tol_reg = TOL_RESET;
            errors  = 0;
        endfunction

        // bit-by-bit floor root, widest result fits in CB+1 bits
        function longint floor_sqrt(longint n);
            longint r, t;
            r = 0;
            for (int b = CB + 1; b >= 0; b--) begin
                t = r | (longint'(1) << b);
                if (t * t <= n) r = t;
            end
            return r;
        endfunction

        function bit near(longint p, longint q);
            longint diff;
            diff = (p > q) ? p - q : q - p;
            return diff <= longint'({1'b0, tol_reg});
        endfunction

        function relation_t predict(sphere_pair_t p);
            relation_t r;
            longint    dx, dy, dz, ra, rb, d;
            bit        a_in, b_in;
            dx = longint'(p.ax) - longint'(p.bx);
            dy = longint'(p.ay) - longint'(p.by);
            dz = longint'(p.az) - longint'(p.bz);
            ra = longint'(p.ra);
            rb = longint'(p.rb);
            d  = floor_sqrt(dx * dx + dy * dy + dz * dz);
            a_in = ra >= rb + d;
            b_in = rb >= ra + d;
            r.center_dist   = d[CB:0];
            r.congruent     = near(ra, rb);
            r.concentric    = near(p.ax, p.bx) && near(p.ay, p.by) && near(p.az, p.bz);
            r.identical     = r.congruent && r.concentric;
            r.a_holds_b     = a_in;
            r.b_holds_a     = b_in;
            r.touch_outside = !(a_in || b_in) && near(d, ra + rb);
            r.touch_inside  = (a_in && near(ra, rb + d)) || (b_in && near(rb, ra + d));
            r.overlap       = d < ra + rb;
            r.intersect_res = r.overlap && !(a_in || b_in);
            return r;
        endfunction

        function void note_input(sphere_pair_t p);
            expected_q.push_back(predict(p));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void cmp(string name, longint e, longint g);
            if (e != g) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, g);
                errors++;
            end
        endfunction

        function void check_result(relation_t got);
            relation_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, distance %0d", $time, got.center_dist);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("center_distance", e.center_dist, got.center_dist);
            cmp("identical", e.identical, got.identical);
            cmp("congruent", e.congruent, got.congruent);
            cmp("concentric", e.concentric, got.concentric);
            cmp("a_holds_b", e.a_holds_b, got.a_holds_b);
            cmp("b_holds_a", e.b_holds_a, got.b_holds_a);
            cmp("touch_outside", e.touch_outside, got.touch_outside);
            cmp("touch_inside", e.touch_inside, got.touch_inside);
            cmp("overlap", e.overlap, got.overlap);
            cmp("intersect_res", e.intersect_res, got.intersect_res);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel, penable, pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_valid, o_ready;
    logic signed [CB-1:0] i_a_center_x, i_a_center_y, i_a_center_z;
    logic [CB-2:0]        i_a_radius;
    logic signed [CB-1:0] i_b_center_x, i_b_center_y, i_b_center_z;
    logic [CB-2:0]        i_b_radius;
    logic                 o_valid, i_ready;
    logic [CB:0]          o_center_distance;
    logic                 o_identical, o_congruent, o_concentric, o_a_holds_b, o_b_holds_a;
    logic                 o_touch_outside, o_touch_inside, o_overlap, o_intersect_res;

    relation_scoreboard sb;
    bit                 steady = 1'b0;

    sphere_pair_relation_classifier_unit #(.COORD_BITS(CB)) u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int spread(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic int clamp_r(int v);
        return (v < 0) ? 0 : (v > RMAX) ? RMAX : v;
    endfunction

    function automatic sphere_pair_t mk(int ax, int ay, int az, int ra,
                                        int bx, int by, int bz, int rb);
        sphere_pair_t p;
        p.ax = CB'(ax); p.ay = CB'(ay); p.az = CB'(az); p.ra = (CB-1)'(ra);
        p.bx = CB'(bx); p.by = CB'(by); p.bz = CB'(bz); p.rb = (CB-1)'(rb);
        return p;
    endfunction

    function automatic sphere_pair_t make_pair();
        sphere_pair_t p;
        int kind, t, s, dx, dy, dz, c_dist, k, ra, rb, tmp;
        kind = $urandom_range(0, 99);
        t    = int'(sb.tol_reg);
        if (kind < 15) begin
            return mk($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end
        s  = (kind < 30) ? 0 : $urandom_range(0, 20);
        dx = (kind < 30) ? spread(t + 2) : spread(1 << s);
        dy = (kind < 30) ? spread(t + 2) : spread(1 << s);
        dz = (kind < 30) ? spread(t + 2) : spread(1 << s);
        c_dist = int'(sb.floor_sqrt(longint'(dx) * dx + longint'(dy) * dy
                                    + longint'(dz) * dz));
        k = spread(t + 2);
        if (kind < 30) begin
            ra = $urandom_range(0, RMAX);
            rb = ra + k;
        end else if (kind < 48) begin
            // near external contact
            ra = $urandom_range(0, c_dist);
            rb = c_dist - ra + k;
        end else if (kind < 65) begin
            // near internal contact, either sphere outside
            rb = $urandom_range(0, 1 << 21);
            ra = rb + c_dist + k;
            if ($urandom_range(0, 1)) begin
                tmp = ra; ra = rb; rb = tmp;
            end
        end else begin
            ra = $urandom_range(0, 1 << 21);
            rb = $urandom_range(0, 1 << 21);
        end
        p.ax = CB'(spread(1 << 21));
        p.ay = CB'(spread(1 << 21));
        p.az = CB'(spread(1 << 21));
        p.bx = CB'(p.ax + dx);
        p.by = CB'(p.ay + dy);
        p.bz = CB'(p.az + dz);
        p.ra = (CB-1)'(clamp_r(ra));
        p.rb = (CB-1)'(clamp_r(rb));
        return p;
    endfunction

    task automatic send_pair(input sphere_pair_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_a_center_x <= p.ax;
        i_a_center_y <= p.ay;
        i_a_center_z <= p.az;
        i_a_radius   <= p.ra;
        i_b_center_x <= p.bx;
        i_b_center_y <= p.by;
        i_b_center_z <= p.bz;
        i_b_radius   <= p.rb;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(p);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_pair(make_pair());
    endtask

    // called straight after the last acceptance of a phase
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_EQUAL_TOL) sb.tol_reg = value[TOL_W-1:0];
    endtask

    // result side back-pressure
    initial begin
        int on_len, off_len;
        i_ready <= 1'b0;
        forever begin
            on_len = $urandom_range(1, 30);
            repeat (on_len) begin
                @(posedge i_clk);
                i_ready <= 1'b1;
            end
            off_len = pick_gap();
            repeat (off_len) begin
                @(posedge i_clk);
                i_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        relation_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.center_dist   = o_center_distance;
            got.identical     = o_identical;
            got.congruent     = o_congruent;
            got.concentric    = o_concentric;
            got.a_holds_b     = o_a_holds_b;
            got.b_holds_a     = o_b_holds_a;
            got.touch_outside = o_touch_outside;
            got.touch_inside  = o_touch_inside;
            got.overlap       = o_overlap;
            got.intersect_res = o_intersect_res;
            sb.check_result(got);
        end
    end

    initial begin
        sphere_pair_t directed[$];
        sb = new();
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_valid      <= 1'b0;
        i_a_center_x <= '0;
        i_a_center_y <= '0;
        i_a_center_z <= '0;
        i_a_radius   <= '0;
        i_b_center_x <= '0;
        i_b_center_y <= '0;
        i_b_center_z <= '0;
        i_b_radius   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pairs, reset tolerance of one LSB
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(7, -3, 12, 1000, 7, -3, 12, 1000));
        directed.push_back(mk(CMIN, CMIN, CMIN, RMAX, CMAX, CMAX, CMAX, RMAX));
        directed.push_back(mk(CMAX, CMIN, CMAX, 0, CMIN, CMAX, CMIN, RMAX));
        directed.push_back(mk(CMAX, CMAX, CMAX, RMAX, CMAX, CMAX, CMAX, RMAX - 1));
        directed.push_back(mk(CMIN, 0, 0, 0, CMIN + 1, 0, 0, 0));
        directed.push_back(mk(5, 0, 0, 3, -5, 0, 0, 3));     // opposite signs
        directed.push_back(mk(1, 0, 0, 9, -1, 0, 0, 9));
        directed.push_back(mk(1, -1, 0, 9, 0, 0, 1, 10));    // within tolerance
        directed.push_back(mk(0, 0, 0, 60, 100, 0, 0, 40));  // external contact
        directed.push_back(mk(0, 0, 0, 60, 100, 0, 0, 41));  // contact within tolerance
        directed.push_back(mk(0, 0, 0, 150, 100, 0, 0, 50)); // a holds b, touching
        directed.push_back(mk(0, 0, 0, 10, 0, 30, 0, 40));   // b holds a, touching
        directed.push_back(mk(0, 0, 0, 10, 0, 30, 0, 45));   // b holds a, clear
        directed.push_back(mk(0, 0, 0, 60, 100, 0, 0, 60));  // proper intersection
        directed.push_back(mk(0, 0, 0, 10, 0, 0, -100, 10)); // apart
        directed.push_back(mk(0, 0, 0, 1, 1, 1, 0, 0));      // root rounds down
        directed.push_back(mk(0, 0, 0, 3, 3, 4, 1, 2));
        directed.push_back(mk(0, 0, 0, 500, 0, 0, 0, 502));
        directed.push_back(mk(-2, 2, -2, 77, 2, -2, 2, 77));
        foreach (directed[i]) send_pair(directed[i]);
        drain();

        write_reg(REG_EQUAL_TOL, 32'd0);
        run_random(100);
        drain();

        write_reg(REG_EQUAL_TOL, 32'd255);
        run_random(90);
        drain();

        steady = 1'b1;
        write_reg(REG_UNUSED, 32'h0000_0007);
        run_random(60);
        drain();
        steady = 1'b0;

        // upper data bits must be dropped
        write_reg(REG_EQUAL_TOL, {24'($urandom_range(1, 32'h00FF_FFFF)),
                                  8'(spread(100) + 128)});
        run_random(100);
        drain();

        write_reg(REG_EQUAL_TOL, 32'd1);
        run_random(50);
        drain();

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
